[rtl/calp_pkg.sv]
// Shared types, constants and field widths of the ASCII CAN line parser.
package calp_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int PAY_W     = 64;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 5;
    localparam int ACC_W     = 32;

    // Width of the millisecond counter (16 to 64)
    localparam int TIME_BITS = 32;

    // Identifier limits
    localparam logic [ACC_W-1:0] STD_ID_MAX = 32'h0000_07FF;
    localparam logic [ACC_W-1:0] EXT_ID_MAX = 32'h1FFF_FFFF;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_STD_DAT = 8'h74;  // t
    localparam logic [BYTE_W-1:0] CHAR_STD_RTR = 8'h54;  // T
    localparam logic [BYTE_W-1:0] CHAR_EXT_DAT = 8'h65;  // e
    localparam logic [BYTE_W-1:0] CHAR_EXT_RTR = 8'h45;  // E

    // Identifier digit counts
    localparam logic [POS_W-1:0] STD_ID_DIGITS = 5'd3;
    localparam logic [POS_W-1:0] EXT_ID_DIGITS = 5'd8;
    localparam logic [POS_W-1:0] POS_MAX       = 5'd31;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_e;

    // Classified request passed from front to back
    typedef struct packed {
        op_e              op;
        logic             is_cr;
        logic             type_ok;
        logic             type_ext;
        logic             type_rem;
        logic             hex_ok;
        logic [3:0]       hex_val;
        logic             len_ok;
        logic [LEN_W-1:0] len_val;
    } cmd_t;

    // Queue status
    typedef struct packed {
        logic [1:0] level;
    } fifo_stat_t;

    // Parser status
    typedef struct packed {
        logic pos_zero;
        logic line_bad;
    } back_stat_t;

endpackage

[rtl/calp_if.sv]
// Valid/ready channel interfaces for parser input requests and decoded frames.
interface calp_in_if
    import calp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface calp_out_if
    import calp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic              extended;
    logic              remote;
    logic [LEN_W-1:0]  length;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output frame_id, output extended, output remote,
                    output length, output payload, output time_ms, input ready);
    modport sink   (input valid, input frame_id, input extended, input remote,
                    input length, input payload, input time_ms, output ready);
endinterface

[rtl/calp_front.sv]
// Front end: accepts input requests and classifies each character.
module calp_front
    import calp_pkg::*;
(
    calp_in_if.sink rx,
    output logic    push_valid,
    input  logic    push_ready,
    output cmd_t    push_cmd
);

    logic [BYTE_W-1:0] b;

    assign b          = rx.data_byte;
    assign rx.ready   = push_ready;
    assign push_valid = rx.valid;

    // Character classification
    always_comb
    begin
        push_cmd          = '0;
        push_cmd.op       = op_e'(rx.op);
        push_cmd.is_cr    = (b == CHAR_CR);
        push_cmd.type_ok  = (b == CHAR_STD_DAT) || (b == CHAR_STD_RTR) ||
                            (b == CHAR_EXT_DAT) || (b == CHAR_EXT_RTR);
        push_cmd.type_ext = (b == CHAR_EXT_DAT) || (b == CHAR_EXT_RTR);
        push_cmd.type_rem = (b == CHAR_STD_RTR) || (b == CHAR_EXT_RTR);

        // hex digit value
        if (b inside {[8'h30:8'h39]})
        begin
            push_cmd.hex_ok  = 1'b1;
            push_cmd.hex_val = b[3:0];
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            push_cmd.hex_ok  = 1'b1;
            push_cmd.hex_val = 4'(b - 8'h57);
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            push_cmd.hex_ok  = 1'b1;
            push_cmd.hex_val = 4'(b - 8'h37);
        end

        // length digit 0..8
        push_cmd.len_ok  = b inside {[8'h30:8'h38]};
        push_cmd.len_val = b[LEN_W-1:0];
    end

endmodule

[rtl/calp_fifo.sv]
// Two-entry queue of classified requests between front and back.
module calp_fifo
    import calp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  cmd_t       push_cmd,
    output logic       pop_valid,
    input  logic       pop_ready,
    output cmd_t       pop_cmd,
    output fifo_stat_t stat
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;
    logic       push;
    logic       pop;

    assign push_ready = (level_reg != 2'd2);
    assign pop_valid  = (level_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign stat.level = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/calp_back.sv]
// Back end: line parser state, millisecond counter and frame output register.
module calp_back
    import calp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_cmd,
    calp_out_if.source  frame,
    output back_stat_t  stat
);

    logic [POS_W-1:0]     pos_reg,  pos_next;
    logic                 ext_reg,  ext_next;
    logic                 rem_reg,  rem_next;
    logic [ACC_W-1:0]     id_reg,   id_next;
    logic [LEN_W-1:0]     len_reg,  len_next;
    logic [PAY_W-1:0]     pay_reg,  pay_next;
    logic                 bad_reg,  bad_next;
    logic [TIME_BITS-1:0] ms_reg,   ms_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_ext_reg;
    logic                 out_rem_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [PAY_W-1:0]     out_pay_reg;
    logic [TIME_W-1:0]    out_time_reg;

    logic                 pop;
    logic                 emit;
    logic [POS_W-1:0]     id_digits;
    logic [POS_W-1:0]     data_idx;
    logic [3:0]           nib;
    logic [POS_W-1:0]     need;
    logic [ACC_W-1:0]     id_max;
    logic [63:0]          ms_wide;

    assign pop_ready = !out_valid_reg || frame.ready;
    assign pop       = pop_valid && pop_ready;

    assign id_digits = ext_reg ? EXT_ID_DIGITS : STD_ID_DIGITS;
    assign data_idx  = pos_reg - id_digits - 5'd2;
    assign nib       = {data_idx[3:1], ~data_idx[0]};
    assign need      = 5'd2 + id_digits + (rem_reg ? 5'd0 : {len_reg, 1'b0});
    assign id_max    = ext_reg ? EXT_ID_MAX : STD_ID_MAX;
    assign ms_wide   = 64'(ms_reg);

    // Line completion check
    assign emit = pop && (pop_cmd.op == OP_BYTE) && pop_cmd.is_cr &&
                  (pos_reg != '0) && !bad_reg && (pos_reg >= need) &&
                  (id_reg <= id_max);

    // Parser state update
    always_comb
    begin
        pos_next = pos_reg;
        ext_next = ext_reg;
        rem_next = rem_reg;
        id_next  = id_reg;
        len_next = len_reg;
        pay_next = pay_reg;
        bad_next = bad_reg;
        ms_next  = ms_reg;

        if (pop)
        begin
            case (pop_cmd.op)
                OP_BYTE:
                begin
                    if (pop_cmd.is_cr)
                    begin
                        // end of line: start over
                        pos_next = '0;
                        ext_next = 1'b0;
                        rem_next = 1'b0;
                        id_next  = '0;
                        len_next = '0;
                        pay_next = '0;
                        bad_next = 1'b0;
                    end
                    else
                    begin
                        if (!bad_reg)
                        begin
                            if (pos_reg == '0)
                            begin
                                if (pop_cmd.type_ok)
                                begin
                                    ext_next = pop_cmd.type_ext;
                                    rem_next = pop_cmd.type_rem;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                            else if (pos_reg <= id_digits)
                            begin
                                if (pop_cmd.hex_ok)
                                begin
                                    id_next = {id_reg[ACC_W-5:0], pop_cmd.hex_val};
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                            else if (pos_reg == id_digits + 5'd1)
                            begin
                                if (pop_cmd.len_ok)
                                begin
                                    len_next = pop_cmd.len_val;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                            else if (!rem_reg && (data_idx < {len_reg, 1'b0}))
                            begin
                                if (pop_cmd.hex_ok)
                                begin
                                    pay_next[{nib, 2'b00} +: 4] =
                                        pay_reg[{nib, 2'b00} +: 4] | pop_cmd.hex_val;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        if (pos_reg != POS_MAX)
                        begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                OP_TICK:
                begin
                    ms_next = ms_reg + TIME_BITS'(1);
                end
                OP_CLEAR:
                begin
                    pos_next = '0;
                    ext_next = 1'b0;
                    rem_next = 1'b0;
                    id_next  = '0;
                    len_next = '0;
                    pay_next = '0;
                    bad_next = 1'b0;
                    ms_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ext_reg       <= 1'b0;
            rem_reg       <= 1'b0;
            id_reg        <= '0;
            len_reg       <= '0;
            pay_reg       <= '0;
            bad_reg       <= 1'b0;
            ms_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ext_reg       <= ext_next;
            rem_reg       <= rem_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            pay_reg       <= pay_next;
            bad_reg       <= bad_next;
            ms_reg        <= ms_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame payload register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg   <= id_reg[ID_W-1:0];
            out_ext_reg  <= ext_reg;
            out_rem_reg  <= rem_reg;
            out_len_reg  <= len_reg;
            out_pay_reg  <= rem_reg ? '0 : pay_reg;
            out_time_reg <= ms_wide[TIME_W-1:0];
        end
    end

    assign frame.valid    = out_valid_reg;
    assign frame.frame_id = out_id_reg;
    assign frame.extended = out_ext_reg;
    assign frame.remote   = out_rem_reg;
    assign frame.length   = out_len_reg;
    assign frame.payload  = out_pay_reg;
    assign frame.time_ms  = out_time_reg;

    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.line_bad  = bad_reg;

endmodule

[rtl/can_ascii_line_parser_core.sv]
// Top level of the ASCII CAN line parser: front, request queue and back.
// Takes one request per cycle while the queue has room (a received character,
// a millisecond tick or a clear) and delivers one decoded CAN frame for every
// well-formed line when its carriage return is processed. A request passes
// through the classifier into a two-entry queue and is handled by the parser
// once it reaches the head of the queue. Frame valid is registered: it rises at
// the clock edge at which the parser takes the carriage return. The parser handles
// one request per cycle while the frame output register is free or being
// drained; a stalled frame output backs the queue up, and input ready drops
// once both queue entries are full. No clearing pass follows reset.
module can_ascii_line_parser_core
    import calp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    calp_in_if.sink     rx,
    calp_out_if.source  frame
);

    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop_ready;
    cmd_t       pop_cmd;
    fifo_stat_t fifo_stat;
    back_stat_t back_stat;

    calp_front u_front (
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    calp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .stat       (fifo_stat)
    );

    calp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .frame      (frame),
        .stat       (back_stat)
    );

    // A new frame only follows a carriage return taken by the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame.valid) |-> $past(pop_valid && pop_ready &&
            (pop_cmd.op == OP_BYTE) && pop_cmd.is_cr))
    else $error("frame raised without a carriage return");

    // A clear leaves the parser at the start of a clean line
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && (pop_cmd.op == OP_CLEAR)) |=>
            (back_stat.pos_zero && !back_stat.line_bad))
    else $error("line state not cleared");

    // Empty queue never offers a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_stat.level == 2'd0) |-> !pop_valid)
    else $error("queue offers a request while empty");

    // Queue never holds more than two requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_stat.level != 2'd3))
    else $error("queue level out of range");

endmodule

[tb/sv/calp_frame_check.sv]
// Frame predictor and scoreboard that watch both channels of the ASCII CAN line parser.
`timescale 1ns / 100ps
module calp_frame_check
    import calp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    calp_in_if   rx,
    calp_out_if  frame,
    output int   fail_count,
    output int   frames_pending
);

    // One decoded frame as it appears on the output channel
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              ext;
        logic              rem;
        logic [LEN_W-1:0]  len;
        logic [PAY_W-1:0]  data;
        logic [TIME_W-1:0] ms;
    } can_frame_t;

    // Predicted state of the line in progress
    logic [POS_W-1:0]     line_pos;
    logic                 line_ext;
    logic                 line_rem;
    logic [ACC_W-1:0]     id_acc;
    logic [LEN_W-1:0]     len_digit;
    logic [PAY_W-1:0]     data_acc;
    logic                 line_bad;
    logic [TIME_BITS-1:0] ms_count;

    can_frame_t frames_due[$];
    int errs = 0;
    int due  = 0;

    assign fail_count     = errs;
    assign frames_pending = due;

    // Value of a hex character, bit 4 set when the character is not hex
    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b0, c[3:0]} + 5'd9;
        return 5'd16;
    endfunction

    task automatic reset_line();
        line_pos  = '0;
        line_ext  = 1'b0;
        line_rem  = 1'b0;
        id_acc    = '0;
        len_digit = '0;
        data_acc  = '0;
        line_bad  = 1'b0;
    endtask

    // Fold one non-CR character into the line state
    task automatic take_byte(input logic [BYTE_W-1:0] c);
        int unsigned id_digits;
        int unsigned d;
        int unsigned sh;
        logic [4:0]  nib;
        id_digits = line_ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
        nib = nibble_of(c);
        if (!line_bad) begin
            if (line_pos == 0) begin
                if (c == CHAR_STD_DAT || c == CHAR_STD_RTR ||
                    c == CHAR_EXT_DAT || c == CHAR_EXT_RTR)
                begin
                    line_ext = (c == CHAR_EXT_DAT || c == CHAR_EXT_RTR);
                    line_rem = (c == CHAR_STD_RTR || c == CHAR_EXT_RTR);
                end
                else
                begin
                    line_bad = 1'b1;
                end
            end
            else if (line_pos <= id_digits)
            begin
                if (nib[4])
                    line_bad = 1'b1;
                else
                    id_acc = {id_acc[ACC_W-5:0], nib[3:0]};
            end
            else if (line_pos == id_digits + 1)
            begin
                if (c >= "0" && c <= "8")
                    len_digit = c[LEN_W-1:0];
                else
                    line_bad = 1'b1;
            end
            else if (!line_rem)
            begin
                // data digits, high nibble first within each byte
                d = line_pos - id_digits - 2;
                if (d < 2 * len_digit) begin
                    if (nib[4]) begin
                        line_bad = 1'b1;
                    end
                    else
                    begin
                        sh = 8 * (d >> 1) + ((d & 1) ? 0 : 4);
                        data_acc = data_acc | (PAY_W'(nib[3:0]) << sh);
                    end
                end
            end
        end
        if (line_pos < POS_MAX)
            line_pos = line_pos + 5'd1;
    endtask

    // Carriage return: queue a frame if the line is complete and good
    task automatic close_line();
        int unsigned      id_digits;
        int unsigned      need;
        logic [ACC_W-1:0] id_max;
        can_frame_t       f;
        id_digits = line_ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
        need      = 2 + id_digits + (line_rem ? 0 : 2 * len_digit);
        id_max    = line_ext ? EXT_ID_MAX : STD_ID_MAX;
        if (line_pos != 0 && !line_bad && line_pos >= need && id_acc <= id_max) begin
            f.id   = id_acc[ID_W-1:0];
            f.ext  = line_ext;
            f.rem  = line_rem;
            f.len  = len_digit;
            f.data = line_rem ? '0 : data_acc;
            f.ms   = TIME_W'(ms_count);
            frames_due.insert(frames_due.size(), f);
        end
        reset_line();
    endtask

    // Predict on accepted requests, compare accepted frames
    always @(posedge clk or negedge rst_n)
    begin
        can_frame_t got;
        can_frame_t want;
        if (!rst_n) begin
            reset_line();
            ms_count = '0;
            frames_due.delete();
            due <= 0;
        end
        else
        begin
            if (rx.valid && rx.ready) begin
                case (rx.op)
                    OP_BYTE:
                    begin
                        if (rx.data_byte == CHAR_CR)
                            close_line();
                        else
                            take_byte(rx.data_byte);
                    end
                    OP_TICK:
                    begin
                        ms_count = ms_count + 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        reset_line();
                        ms_count = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (frame.valid && frame.ready) begin
                got = '{frame.frame_id, frame.extended, frame.remote, frame.length,
                        frame.payload, frame.time_ms};
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame id=%h ext=%0d rem=%0d len=%0d data=%h ms=%0d",
                             $time, got.id, got.ext, got.rem, got.len, got.data, got.ms);
                    errs <= errs + 1;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: frame mismatch expected id=%h ext=%0d rem=%0d len=%0d data=%h ms=%0d",
                                 $time, want.id, want.ext, want.rem, want.len, want.data,
                                 want.ms);
                        $display("%0t:                  actual id=%h ext=%0d rem=%0d len=%0d data=%h ms=%0d",
                                 $time, got.id, got.ext, got.rem, got.len, got.data, got.ms);
                        errs <= errs + 1;
                    end
                end
            end
            due <= frames_due.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top of the ASCII CAN line parser: clock, reset, line stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import calp_pkg::*;

    localparam int ITEM_TARGET  = 1800;
    localparam int IDLE_PCT     = 22;
    localparam int STEADY_FROM  = 800;
    localparam int STEADY_TO    = 1100;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // Op code the block ignores
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    calp_in_if  rx();
    calp_out_if frame();

    int fail_count;
    int frames_pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    logic [BYTE_W-1:0] line_chars[$];

    can_ascii_line_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .frame (frame)
    );

    calp_frame_check frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx),
        .frame          (frame),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Frame sink stalls at random outside the steady window
    always @(negedge clk)
    begin
        frame.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return {4'h3, v};
        return ($urandom_range(1) ? "a" : "A") + 8'(v - 4'd10);
    endfunction

    function automatic logic [BYTE_W-1:0] non_cr_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(255));
        return (b == CHAR_CR) ? 8'h00 : b;
    endfunction

    // Present one request at a falling edge and hold it until accepted
    task automatic send_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid     <= 1'b1;
        rx.op        <= op;
        rx.data_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        if (op != OP_SPARE)
            items_sent++;
        steady = (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_req(OP_BYTE, s[i]);
    endtask

    // Append one character to the line being built
    task automatic add_char(input logic [BYTE_W-1:0] c);
        line_chars.insert(line_chars.size(), c);
    endtask

    task automatic add_hex(input logic [31:0] val, input int ndig);
        for (int i = ndig - 1; i >= 0; i--)
            add_char(hex_char(val[4*i +: 4]));
    endtask

    // Mostly well-formed lines with random content, a quarter of them broken
    task automatic build_line();
        logic [BYTE_W-1:0] letter;
        logic [31:0]       id;
        int unsigned       len;
        int unsigned       n;
        int unsigned       k;
        bit                ext;
        bit                rem;
        line_chars.delete();
        case ($urandom_range(3))
            0:       letter = CHAR_STD_DAT;
            1:       letter = CHAR_STD_RTR;
            2:       letter = CHAR_EXT_DAT;
            default: letter = CHAR_EXT_RTR;
        endcase
        ext = (letter == CHAR_EXT_DAT || letter == CHAR_EXT_RTR);
        rem = (letter == CHAR_STD_RTR || letter == CHAR_EXT_RTR);
        case ($urandom_range(9))
            0:       id = '0;
            1:       id = ext ? EXT_ID_MAX : STD_ID_MAX;
            default: id = ext ? $urandom_range(EXT_ID_MAX) : $urandom_range(STD_ID_MAX);
        endcase
        len = $urandom_range(8);
        add_char(letter);
        add_hex(id, ext ? EXT_ID_DIGITS : STD_ID_DIGITS);
        add_char(8'("0" + len));
        // remote frames sometimes carry digits that must be ignored
        n = rem ? (($urandom_range(4) == 0) ? $urandom_range(16) : 0) : 2 * len;
        for (k = 0; k < n; k++)
            add_char(hex_char(4'($urandom_range(15))));
        // surplus text, long enough at times to saturate the position count
        if ($urandom_range(6) == 0)
            repeat ($urandom_range(30, 1))
                add_char(8'($urandom_range(126, 32)));
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(6))
                0:
                begin
                    line_chars[0] = non_cr_byte();
                end
                1:
                begin
                    k = $urandom_range(line_chars.size() - 1, 1);
                    case ($urandom_range(3))
                        0:       line_chars[k] = "g";
                        1:       line_chars[k] = ":";
                        2:       line_chars[k] = "@";
                        default: line_chars[k] = non_cr_byte();
                    endcase
                end
                2:
                begin
                    line_chars[ext ? 9 : 4] = $urandom_range(1) ? "9" : non_cr_byte();
                end
                3:
                begin
                    k = $urandom_range(line_chars.size() - 1);
                    while (line_chars.size() > k)
                        void'(line_chars.pop_back());
                end
                4:
                begin
                    // leading digit too large for the identifier range
                    line_chars[1] = hex_char(4'($urandom_range(15, ext ? 2 : 8)));
                end
                5:
                begin
                    line_chars.delete();
                    repeat ($urandom_range(40, 1))
                        add_char(8'($urandom_range(255)));
                end
                default:
                begin
                    line_chars.delete();
                end
            endcase
        end
    endtask

    // Send the built line with ticks, clears and ignored ops mixed in
    task automatic send_line();
        foreach (line_chars[i]) begin
            if ($urandom_range(99) < 3)
                send_req(OP_TICK, 8'($urandom_range(255)));
            if ($urandom_range(99) == 0)
                send_req(OP_SPARE, 8'($urandom_range(255)));
            if ($urandom_range(299) == 0)
                send_req(OP_CLEAR, 8'($urandom_range(255)));
            send_req(OP_BYTE, line_chars[i]);
        end
        // now and then the line runs on into the next one
        if ($urandom_range(29) != 0)
            send_req(OP_BYTE, CHAR_CR);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1))
                send_req(OP_TICK, 8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        rx.valid     = 1'b0;
        rx.op        = OP_BYTE;
        rx.data_byte = '0;
        frame.ready  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty line, ignored op, largest identifiers, clear
        send_req(OP_BYTE, CHAR_CR);
        send_req(OP_TICK, 8'hFF);
        send_req(OP_SPARE, 8'hFF);
        send_text("t7FF0");
        send_req(OP_BYTE, CHAR_CR);
        send_text("E1FFFFFFF0");
        send_req(OP_BYTE, CHAR_CR);
        send_req(OP_CLEAR, 8'h00);

        // Random lines
        while (items_sent < ITEM_TARGET) begin
            build_line();
            send_line();
        end

        // Unterminated tail: never produces a frame
        send_text("t12");
        rx.valid <= 1'b0;

        while (frames_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
